### hdl/slli_pkg.sv
// Package for the sorted linked list insert block.
// Holds payload widths, command and status codes, controller states and the
// command/status structs shared by the controller and the datapath.
package slli_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_IN_W = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REWIND = 2'd1,
    CMD_NEXT   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_END  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RES_OK,
    RES_FULL,
    RES_END,
    RES_INSERT,
    RES_READ
  } res_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LINK_NEW,
    S_LINK_PREV,
    S_READ,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic     req_ready;
    logic     start_insert;
    logic     rewind;
    logic     read_issue;
    logic     read_done;
    logic     walk_adv;
    logic     link_new;
    logic     link_prev;
    logic     res_load;
    res_sel_e res_sel;
    logic     emit;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic head_valid;
    logic cursor_valid;
    logic key_gt;
    logic link_valid;
    logic out_free;
  } stat_t;

endpackage

### hdl/slli_if.sv
// Request and response channel interfaces for the sorted linked list insert block.
// Depends on slli_pkg for payload widths.
interface slli_req_if;
  logic                          valid;
  logic                          ready;
  logic [slli_pkg::CMD_W-1:0]    cmd;
  logic [slli_pkg::KEY_IN_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

interface slli_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [slli_pkg::STATUS_W-1:0] status;
  logic [slli_pkg::SLOT_W-1:0]   slot;
  logic [slli_pkg::KEY_IN_W-1:0] slot_key;

  modport source (output valid, output status, output slot, output slot_key, input ready);
  modport sink (input valid, input status, input slot, input slot_key, output ready);
endinterface

### hdl/slli_ctrl.sv
// Controller state machine for the sorted linked list insert block.
// Sequences insert walks, cursor reads and responses; depends on slli_pkg.
module slli_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [slli_pkg::CMD_W-1:0] req_cmd_i,
  input  slli_pkg::stat_t            stat_i,
  output slli_pkg::ctrl_t            ctrl_o
);

  slli_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slli_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      slli_pkg::S_IDLE: begin
        if (req_valid_i) begin
          case (slli_pkg::cmd_e'(req_cmd_i))
            slli_pkg::CMD_INSERT: begin
              if (stat_i.full) begin
                state_d = slli_pkg::S_EMIT;
              end else if (stat_i.head_valid) begin
                state_d = slli_pkg::S_WALK;
              end else begin
                state_d = slli_pkg::S_LINK_NEW;
              end
            end
            slli_pkg::CMD_NEXT: begin
              state_d = stat_i.cursor_valid ? slli_pkg::S_READ : slli_pkg::S_EMIT;
            end
            default: state_d = slli_pkg::S_EMIT;
          endcase
        end
      end
      slli_pkg::S_WALK: begin
        if (stat_i.key_gt || !stat_i.link_valid) begin
          state_d = slli_pkg::S_LINK_NEW;
        end
      end
      slli_pkg::S_LINK_NEW:  state_d = slli_pkg::S_LINK_PREV;
      slli_pkg::S_LINK_PREV: state_d = slli_pkg::S_EMIT;
      slli_pkg::S_READ:      state_d = slli_pkg::S_EMIT;
      slli_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          state_d = slli_pkg::S_IDLE;
        end
      end
      default: state_d = slli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.res_sel = slli_pkg::RES_OK;
    case (state_q)
      slli_pkg::S_IDLE: begin
        ctrl_o.req_ready = 1'b1;
        if (req_valid_i) begin
          case (slli_pkg::cmd_e'(req_cmd_i))
            slli_pkg::CMD_INSERT: begin
              if (stat_i.full) begin
                ctrl_o.res_load = 1'b1;
                ctrl_o.res_sel  = slli_pkg::RES_FULL;
              end else begin
                ctrl_o.start_insert = 1'b1;
              end
            end
            slli_pkg::CMD_REWIND: begin
              ctrl_o.rewind   = 1'b1;
              ctrl_o.res_load = 1'b1;
            end
            slli_pkg::CMD_NEXT: begin
              if (stat_i.cursor_valid) begin
                ctrl_o.read_issue = 1'b1;
              end else begin
                ctrl_o.res_load = 1'b1;
                ctrl_o.res_sel  = slli_pkg::RES_END;
              end
            end
            default: ctrl_o.res_load = 1'b1;
          endcase
        end
      end
      slli_pkg::S_WALK: begin
        ctrl_o.walk_adv = !stat_i.key_gt;
      end
      slli_pkg::S_LINK_NEW: begin
        ctrl_o.link_new = 1'b1;
      end
      slli_pkg::S_LINK_PREV: begin
        ctrl_o.link_prev = 1'b1;
        ctrl_o.res_load  = 1'b1;
        ctrl_o.res_sel   = slli_pkg::RES_INSERT;
      end
      slli_pkg::S_READ: begin
        ctrl_o.read_done = 1'b1;
        ctrl_o.res_load  = 1'b1;
        ctrl_o.res_sel   = slli_pkg::RES_READ;
      end
      slli_pkg::S_EMIT: begin
        ctrl_o.emit = stat_i.out_free;
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule

### hdl/slli_datapath.sv
// Datapath for the sorted linked list insert block: key and link memories,
// head, fill count, walk and read pointers, and the response register.
// Depends on slli_pkg; driven by slli_ctrl through ctrl_t and stat_t.
module slli_datapath #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slli_pkg::ctrl_t               ctrl_i,
  input  logic [slli_pkg::KEY_IN_W-1:0] req_key_i,
  output slli_pkg::stat_t               stat_o,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic [slli_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [slli_pkg::SLOT_W-1:0]   rsp_slot_o,
  output logic [slli_pkg::KEY_IN_W-1:0] rsp_slot_key_o
);

  localparam int KW    = (KEY_WIDTH < slli_pkg::KEY_IN_W) ? KEY_WIDTH : slli_pkg::KEY_IN_W;
  localparam int PTR_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

  logic [KW-1:0]    key_mem  [CAPACITY];
  logic [PTR_W-1:0] link_mem [CAPACITY];

  logic [KW-1:0]    rd_key_q;
  logic [PTR_W-1:0] rd_link_q;
  logic [KW-1:0]    key_q;
  logic [IDX_W-1:0] fresh_q;
  logic [PTR_W-1:0] at_q, before_q;
  logic [PTR_W-1:0] head_q, used_q, cursor_q;

  slli_pkg::status_e            res_status_q;
  logic [slli_pkg::SLOT_W-1:0]  res_slot_q;
  logic [slli_pkg::KEY_IN_W-1:0] res_key_q;

  logic                          rsp_valid_q;
  slli_pkg::status_e             rsp_status_q;
  logic [slli_pkg::SLOT_W-1:0]   rsp_slot_q;
  logic [slli_pkg::KEY_IN_W-1:0] rsp_key_q;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             link_we;
  logic [IDX_W-1:0] link_widx;
  logic [PTR_W-1:0] link_wdata;
  logic [KW-1:0]    key_in;
  logic             head_valid, cursor_valid, at_valid, before_valid, link_valid;

  assign key_in       = req_key_i[KW-1:0];
  assign head_valid   = head_q < NULL_PTR;
  assign cursor_valid = cursor_q < NULL_PTR;
  assign at_valid     = at_q < NULL_PTR;
  assign before_valid = before_q < NULL_PTR;
  assign link_valid   = rd_link_q < NULL_PTR;

  always_comb begin
    rd_en  = 1'b0;
    rd_idx = head_q[IDX_W-1:0];
    if (ctrl_i.start_insert) begin
      rd_en  = head_valid;
      rd_idx = head_q[IDX_W-1:0];
    end else if (ctrl_i.read_issue) begin
      rd_en  = 1'b1;
      rd_idx = cursor_q[IDX_W-1:0];
    end else if (ctrl_i.walk_adv) begin
      rd_en  = link_valid;
      rd_idx = rd_link_q[IDX_W-1:0];
    end
  end

  always_comb begin
    link_we    = ctrl_i.link_new || (ctrl_i.link_prev && before_valid);
    link_widx  = fresh_q;
    link_wdata = at_valid ? at_q : NULL_PTR;
    if (ctrl_i.link_prev) begin
      link_widx  = before_q[IDX_W-1:0];
      link_wdata = PTR_W'(fresh_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_insert) begin
      key_mem[used_q[IDX_W-1:0]] <= key_in;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_widx] <= link_wdata;
    end
    if (rd_en) begin
      rd_link_q <= link_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_insert) begin
      key_q    <= key_in;
      fresh_q  <= used_q[IDX_W-1:0];
      at_q     <= head_q;
      before_q <= NULL_PTR;
    end else if (ctrl_i.walk_adv) begin
      before_q <= at_q;
      at_q     <= rd_link_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= NULL_PTR;
      used_q   <= '0;
      cursor_q <= NULL_PTR;
    end else begin
      if (ctrl_i.link_prev) begin
        used_q <= used_q + PTR_W'(1);
        if (!before_valid) begin
          head_q <= PTR_W'(fresh_q);
        end
      end
      if (ctrl_i.rewind) begin
        cursor_q <= head_q;
      end else if (ctrl_i.read_done) begin
        cursor_q <= rd_link_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      res_status_q <= slli_pkg::ST_OK;
      res_slot_q   <= '0;
      res_key_q    <= '0;
      case (ctrl_i.res_sel)
        slli_pkg::RES_FULL: res_status_q <= slli_pkg::ST_FULL;
        slli_pkg::RES_END:  res_status_q <= slli_pkg::ST_END;
        slli_pkg::RES_INSERT: begin
          res_slot_q <= slli_pkg::SLOT_W'(fresh_q);
        end
        slli_pkg::RES_READ: begin
          res_slot_q <= slli_pkg::SLOT_W'(cursor_q[IDX_W-1:0]);
          res_key_q  <= slli_pkg::KEY_IN_W'(rd_key_q);
        end
        default: res_status_q <= slli_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      rsp_status_q <= res_status_q;
      rsp_slot_q   <= res_slot_q;
      rsp_key_q    <= res_key_q;
    end
  end

  assign stat_o.full         = used_q >= NULL_PTR;
  assign stat_o.head_valid   = head_valid;
  assign stat_o.cursor_valid = cursor_valid;
  assign stat_o.key_gt       = rd_key_q > key_q;
  assign stat_o.link_valid   = link_valid;
  assign stat_o.out_free     = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_status_o   = rsp_status_q;
  assign rsp_slot_o     = rsp_slot_q;
  assign rsp_slot_key_o = rsp_key_q;

endmodule

### hdl/sorted_linked_list_insert.sv
// Sorted linked list insert: top level joining slli_ctrl and slli_datapath.
// Insert compares m entries (at most CAPACITY-1) from the head, one link
// per cycle through the link memory read port, then links the new entry.
// Refused insert, rewind and unused commands skip the memories.
// One request at a time; a new request is taken while a response waits.
// Reset clears head, cursor and fill count; the memories are not cleared.
module sorted_linked_list_insert #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slli_req_if.sink   req_i,
  slli_rsp_if.source rsp_o
);

  slli_pkg::ctrl_t ctrl;
  slli_pkg::stat_t stat;

  slli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  slli_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .req_key_i      (req_i.key),
    .stat_o         (stat),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_status_o   (rsp_o.status),
    .rsp_slot_o     (rsp_o.slot),
    .rsp_slot_key_o (rsp_o.slot_key)
  );

  assign req_i.ready = ctrl.req_ready;

  a_no_link_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.link_prev |-> !stat.full)
    else $error("link committed while table full");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> stat.out_free)
    else $error("response loaded over a pending response");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one still in progress");

  a_walk_stops_on_greater: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.walk_adv |-> !stat.key_gt)
    else $error("walk advanced past a greater key");

endmodule
